@@ src/pmau_pkg.sv @@
// Shared types and constants of the prime modular arithmetic unit.
// Used by the controller, the datapath and the top level.
package pmau_pkg;

  localparam int unsigned RES_W = 31;
  localparam int unsigned LEN_W = 7;
  localparam logic [RES_W-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [3:0] CMD_REDUCE = 4'd0;
  localparam logic [3:0] CMD_ADD    = 4'd1;
  localparam logic [3:0] CMD_SUB    = 4'd2;
  localparam logic [3:0] CMD_NEG    = 4'd3;
  localparam logic [3:0] CMD_INC    = 4'd4;
  localparam logic [3:0] CMD_DEC    = 4'd5;
  localparam logic [3:0] CMD_MUL    = 4'd6;
  localparam logic [3:0] CMD_DIV    = 4'd7;
  localparam logic [3:0] CMD_POW    = 4'd8;
  localparam logic [3:0] CMD_INV    = 4'd9;
  localparam logic [3:0] CMD_EQUAL  = 4'd10;

  // jobs of the serial shift-add-reduce unit
  typedef enum logic [2:0] {
    UOP_NONE,
    UOP_RED_A,     // a_r   = operand a mod m (signed)
    UOP_RED_B,     // b_r   = operand b mod m
    UOP_RED_E,     // e_r   = operand b mod (m-1)
    UOP_MUL_AB,    // res_r = a*b mod m
    UOP_MUL_A_ACC, // res_r = a*acc mod m
    UOP_MUL_ACC,   // acc_r = acc*base mod m
    UOP_SQR        // base_r = base*base mod m, e_r >>= 1
  } uop_t;

  typedef struct packed {
    logic load;
    logic go;
    uop_t op;
    logic pow_init;
    logic res_simple;
    logic res_acc;
  } dp_ctrl_t;

  typedef struct packed {
    logic       unit_done;
    logic       m_small;
    logic [3:0] cmd;
    logic       a_zero;
    logic       b_zero;
    logic       e_zero;
    logic       e_lsb;
  } dp_stat_t;

endpackage

@@ src/prime_modular_arithmetic_unit.sv @@
// Top level of the prime modular arithmetic unit.
// Instantiates pmau_ctrl and pmau_datapath; types from pmau_pkg.
//
// Usage:
//   A command beat is taken at a clock edge with start high and busy low:
//   in_command, in_operand_a (signed) and in_operand_b. One result beat per
//   command appears on out_result with out_valid high for exactly one cycle.
//   The receiver cannot stall; out_result holds until the next command ends.
//   While a result is shown busy is low, so the next command may be taken then.
//   cfg_we/cfg_wdata write the modulus; write it only while the unit is idle.
//   Reset (rst_n low, synchronous) sets the modulus to 1000000007 and idles.
// Sequenced on one bit-serial shift-add-reduce unit handling 1 bit per cycle:
//   operand reduction covers 64 + 63 bits plus handoff; simple commands then finish,
//   and multiply runs one 31-bit modular multiply. Power first reduces the exponent
//   modulo m-1, then each exponent bit costs a multiply into the accumulator if the
//   bit is set and a squaring of the base. Inverse and divide use exponent m-2, and
//   divide ends with a multiply by operand a. No command is taken while one runs.
//   With a modulus below 2 the result is set without reducing the operands.
module prime_modular_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_command,
  input  logic [63:0]                 in_operand_a,
  input  logic [62:0]                 in_operand_b,
  output logic                        out_valid,
  output logic [pmau_pkg::RES_W-1:0]  out_result,
  input  logic                        cfg_we,
  input  logic [pmau_pkg::RES_W-1:0]  cfg_wdata
);
  import pmau_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  pmau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  pmau_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_result   (out_result)
  );

endmodule

@@ src/pmau_serial.sv @@
// Bit-serial modular unit: r = 2r + bit*x mod md, one source bit per cycle, MSB first.
// Serves both operand reduction (x = 1) and modular multiplication. Uses pmau_pkg.
module pmau_serial (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [63:0]                 src_bits,
  input  logic [pmau_pkg::LEN_W-1:0]  src_len,
  input  logic [pmau_pkg::RES_W-1:0]  mul_x,
  input  logic [pmau_pkg::RES_W-1:0]  mod_val,
  output logic                        done,
  output logic [pmau_pkg::RES_W-1:0]  rem
);
  import pmau_pkg::*;

  logic [63:0]      sh_r;
  logic [LEN_W-1:0] cnt_r;
  logic [RES_W-1:0] x_r;
  logic [RES_W-1:0] md_r;
  logic [RES_W-1:0] r_r;
  logic [RES_W-1:0] r_nxt;
  logic             done_r;
  logic [RES_W+2:0] t;
  logic [RES_W+2:0] d1;
  logic [RES_W+2:0] d2;

  // t < 3*md, so at most two subtractions
  always_comb begin
    t  = {2'b00, r_r, 1'b0} + (sh_r[63] ? {3'b000, x_r} : '0);
    d1 = t - {3'b000, md_r};
    d2 = t - {2'b00, md_r, 1'b0};
    if (!d2[RES_W+2]) begin
      r_nxt = d2[RES_W-1:0];
    end else if (!d1[RES_W+2]) begin
      r_nxt = d1[RES_W-1:0];
    end else begin
      r_nxt = t[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == LEN_W'(1));
      if (start) begin
        cnt_r <= src_len;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= src_bits;
      x_r  <= mul_x;
      md_r <= mod_val;
      r_r  <= '0;
    end else if (cnt_r != '0) begin
      sh_r <= {sh_r[62:0], 1'b0};
      r_r  <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

@@ src/pmau_datapath.sv @@
// Datapath: modulus register, operand and exponent registers, simple-op logic
// and the shared serial unit (pmau_serial). Uses pmau_pkg.
module pmau_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [3:0]                  in_command,
  input  logic [63:0]                 in_operand_a,
  input  logic [62:0]                 in_operand_b,
  input  logic                        cfg_we,
  input  logic [pmau_pkg::RES_W-1:0]  cfg_wdata,
  input  pmau_pkg::dp_ctrl_t          ctrl,
  output pmau_pkg::dp_stat_t          stat,
  output logic [pmau_pkg::RES_W-1:0]  out_result
);
  import pmau_pkg::*;

  logic [RES_W-1:0] modulus_r;
  logic [3:0]       cmd_r;
  logic [63:0]      araw_r;
  logic [62:0]      eb_r;
  logic [RES_W-1:0] a_r;
  logic [RES_W-1:0] b_r;
  logic [RES_W-1:0] e_r;
  logic [RES_W-1:0] base_r;
  logic [RES_W-1:0] acc_r;
  logic [RES_W-1:0] res_r;
  uop_t             op_r;

  logic [RES_W-1:0] m_minus1;
  logic [RES_W-1:0] m_minus2;
  logic [63:0]      a_mag;
  logic [63:0]      u_bits;
  logic [LEN_W-1:0] u_len;
  logic [RES_W-1:0] u_x;
  logic [RES_W-1:0] u_md;
  logic [RES_W-1:0] u_y;
  logic             u_done;
  logic [RES_W-1:0] u_rem;
  logic [RES_W:0]   sum;
  logic [RES_W:0]   sum_m;
  logic [RES_W-1:0] simple_val;
  logic [RES_W-1:0] a_fix;

  assign m_minus1 = modulus_r - RES_W'(1);
  assign m_minus2 = modulus_r - RES_W'(2);
  assign a_mag    = araw_r[63] ? (64'd0 - araw_r) : araw_r;

  // operand setup for the serial unit, taken at go
  always_comb begin
    u_bits = {eb_r, 1'b0};
    u_len  = LEN_W'(63);
    u_x    = RES_W'(1);
    u_md   = modulus_r;
    u_y    = acc_r;
    case (ctrl.op)
      UOP_RED_A: begin
        u_bits = a_mag;
        u_len  = LEN_W'(64);
      end
      UOP_RED_E: u_md = m_minus1;
      UOP_MUL_AB: begin
        u_y = b_r;
        u_x = a_r;
      end
      UOP_MUL_A_ACC: u_x = a_r;
      UOP_MUL_ACC:   u_x = base_r;
      UOP_SQR: begin
        u_y = base_r;
        u_x = base_r;
      end
      default: ;
    endcase
    if (ctrl.op == UOP_MUL_AB || ctrl.op == UOP_MUL_A_ACC ||
        ctrl.op == UOP_MUL_ACC || ctrl.op == UOP_SQR) begin
      u_bits = {u_y, 33'd0};
      u_len  = LEN_W'(RES_W);
    end
  end

  pmau_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.go),
    .src_bits (u_bits),
    .src_len  (u_len),
    .mul_x    (u_x),
    .mod_val  (u_md),
    .done     (u_done),
    .rem      (u_rem)
  );

  assign a_fix = (araw_r[63] && u_rem != '0) ? modulus_r - u_rem : u_rem;

  // commands without a serial multiply, and the trivial results of divide, power and inverse
  always_comb begin
    sum        = {1'b0, a_r} + {1'b0, b_r};
    sum_m      = sum - {1'b0, modulus_r};
    simple_val = '0;
    if (modulus_r < RES_W'(2)) begin
      simple_val = RES_W'(cmd_r == CMD_EQUAL);
    end else begin
      case (cmd_r)
        CMD_REDUCE: simple_val = a_r;
        CMD_ADD:    simple_val = sum_m[RES_W] ? sum[RES_W-1:0] : sum_m[RES_W-1:0];
        CMD_SUB:    simple_val = (a_r >= b_r) ? a_r - b_r : a_r - b_r + modulus_r;
        CMD_NEG:    simple_val = (a_r == '0) ? '0 : modulus_r - a_r;
        CMD_INC:    simple_val = (a_r + RES_W'(1) == modulus_r) ? '0 : a_r + RES_W'(1);
        CMD_DEC:    simple_val = (a_r == '0) ? m_minus1 : a_r - RES_W'(1);
        CMD_POW:    simple_val = RES_W'(eb_r == '0);  // zero base
        CMD_EQUAL:  simple_val = RES_W'(a_r == b_r);
        default:    simple_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= UOP_NONE;
    end else if (ctrl.go) begin
      op_r <= ctrl.op;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_command;
      araw_r <= in_operand_a;
      eb_r   <= in_operand_b;
    end
    if (ctrl.pow_init) begin
      acc_r  <= RES_W'(1);
      base_r <= (cmd_r == CMD_DIV) ? b_r : a_r;
      e_r    <= m_minus2;
    end
    if (ctrl.res_simple) begin
      res_r <= simple_val;
    end
    if (ctrl.res_acc) begin
      res_r <= acc_r;
    end
    if (u_done) begin
      case (op_r)
        UOP_RED_A:     a_r <= a_fix;
        UOP_RED_B:     b_r <= u_rem;
        UOP_RED_E:     e_r <= u_rem;
        UOP_MUL_AB:    res_r <= u_rem;
        UOP_MUL_A_ACC: res_r <= u_rem;
        UOP_MUL_ACC:   acc_r <= u_rem;
        UOP_SQR: begin
          base_r <= u_rem;
          e_r    <= {1'b0, e_r[RES_W-1:1]};
        end
        default: ;
      endcase
    end
  end

  assign stat.unit_done = u_done;
  assign stat.m_small   = (modulus_r < RES_W'(2));
  assign stat.cmd       = cmd_r;
  assign stat.a_zero    = (a_r == '0);
  assign stat.b_zero    = (b_r == '0);
  assign stat.e_zero    = (e_r == '0);
  assign stat.e_lsb     = e_r[0];
  assign out_result     = res_r;

endmodule

@@ src/pmau_ctrl.sv @@
// Controller state machine: sequences reduction, simple ops and square-and-multiply.
// Drives the datapath through pmau_pkg::dp_ctrl_t and reads pmau_pkg::dp_stat_t.
module pmau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output pmau_pkg::dp_ctrl_t ctrl,
  input  pmau_pkg::dp_stat_t stat
);
  import pmau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_WAIT_A,
    S_WAIT_B,
    S_DISP,
    S_WAIT_E,
    S_POW_TEST,
    S_WAIT_ACC,
    S_WAIT_SQR,
    S_WAIT_RES,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   accept;

  // a new beat may be taken in the cycle its predecessor is shown
  assign accept = start && (state_r == S_IDLE || state_r == S_EMIT);

  always_comb begin
    state_nxt       = state_r;
    ctrl            = '0;
    ctrl.op         = UOP_NONE;
    case (state_r)
      S_IDLE, S_EMIT: begin
        if (accept) begin
          ctrl.load = 1'b1;
          state_nxt = S_FIRST;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIRST: begin
        if (stat.m_small) begin
          ctrl.res_simple = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          ctrl.go   = 1'b1;
          ctrl.op   = UOP_RED_A;
          state_nxt = S_WAIT_A;
        end
      end
      S_WAIT_A: begin
        if (stat.unit_done) begin
          ctrl.go   = 1'b1;
          ctrl.op   = UOP_RED_B;
          state_nxt = S_WAIT_B;
        end
      end
      S_WAIT_B: begin
        if (stat.unit_done) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_MUL: begin
            ctrl.go   = 1'b1;
            ctrl.op   = UOP_MUL_AB;
            state_nxt = S_WAIT_RES;
          end
          CMD_DIV: begin
            if (stat.b_zero) begin
              ctrl.res_simple = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              ctrl.pow_init = 1'b1;
              state_nxt     = S_POW_TEST;
            end
          end
          CMD_POW: begin
            if (stat.a_zero) begin
              ctrl.res_simple = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              // e_r from pow_init is replaced by b mod (m-1)
              ctrl.pow_init = 1'b1;
              ctrl.go       = 1'b1;
              ctrl.op       = UOP_RED_E;
              state_nxt     = S_WAIT_E;
            end
          end
          CMD_INV: begin
            if (stat.a_zero) begin
              ctrl.res_simple = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              ctrl.pow_init = 1'b1;
              state_nxt     = S_POW_TEST;
            end
          end
          default: begin
            ctrl.res_simple = 1'b1;
            state_nxt       = S_EMIT;
          end
        endcase
      end
      S_WAIT_E: begin
        if (stat.unit_done) begin
          state_nxt = S_POW_TEST;
        end
      end
      S_POW_TEST: begin
        if (stat.e_zero) begin
          if (stat.cmd == CMD_DIV) begin
            ctrl.go   = 1'b1;
            ctrl.op   = UOP_MUL_A_ACC;
            state_nxt = S_WAIT_RES;
          end else begin
            ctrl.res_acc = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else if (stat.e_lsb) begin
          ctrl.go   = 1'b1;
          ctrl.op   = UOP_MUL_ACC;
          state_nxt = S_WAIT_ACC;
        end else begin
          ctrl.go   = 1'b1;
          ctrl.op   = UOP_SQR;
          state_nxt = S_WAIT_SQR;
        end
      end
      S_WAIT_ACC: begin
        if (stat.unit_done) begin
          ctrl.go   = 1'b1;
          ctrl.op   = UOP_SQR;
          state_nxt = S_WAIT_SQR;
        end
      end
      S_WAIT_SQR: begin
        if (stat.unit_done) begin
          state_nxt = S_POW_TEST;
        end
      end
      S_WAIT_RES: begin
        if (stat.unit_done) begin
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_EMIT);
    end
  end

  assign busy      = !(state_r == S_IDLE || state_r == S_EMIT);
  assign out_valid = out_valid_r;

endmodule

@@ tb/prime_modular_arithmetic_unit_tb.sv @@
// Self-checking testbench for prime_modular_arithmetic_unit: directed and random command
// beats over several moduli, each result checked against an in-bench residue predictor.
// Depends on pmau_pkg and the prime_modular_arithmetic_unit RTL only.
module prime_modular_arithmetic_unit_tb;
  import pmau_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2500;
  localparam int RANDOM_PER_PHASE = 190;
  localparam logic [3:0] CMD_FIRST_UNUSED = CMD_EQUAL + 4'd1;
  localparam logic [3:0] CMD_LAST_CODE = 4'hF;
  localparam logic [RES_W-1:0] MOD_MAX = 31'h7FFF_FFFF;
  localparam logic [63:0] A_MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] A_MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] B_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [RES_W-1:0] value;
  } residue_beat_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [3:0]        in_command;
  logic [63:0]       in_operand_a;
  logic [62:0]       in_operand_b;
  logic              out_valid;
  logic [RES_W-1:0]  out_result;
  logic              cfg_we;
  logic [RES_W-1:0]  cfg_wdata;

  residue_beat_t     pending_residues[$];
  residue_beat_t     oldest_residue;
  logic [RES_W-1:0]  modulus_model;
  bit                steady_flow;
  int                n_errors = 0;
  int                quiet_cycles = 0;

  prime_modular_arithmetic_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------- residue predictor ----------------

  function automatic bit [63:0] signed_residue(bit [63:0] raw, bit [63:0] m);
    bit [63:0] r;
    if (!raw[63]) return raw % m;
    r = (64'd0 - raw) % m;
    return (r != 0) ? m - r : 64'd0;
  endfunction

  // square-and-multiply; exponent folded modulo m-1, zero base handled first
  function automatic bit [63:0] modexp(bit [63:0] base, bit [63:0] e_raw, bit [63:0] m);
    bit [63:0] e, acc;
    acc = 64'd1 % m;
    if (base == 0) return (e_raw == 0) ? 64'd1 % m : 64'd0;
    e = e_raw % (m - 64'd1);
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit [63:0] fermat_inverse(bit [63:0] x, bit [63:0] m);
    if (x == 0) return 64'd0;
    return modexp(x, m - 64'd2, m);
  endfunction

  function automatic logic [RES_W-1:0] predict_residue(logic [3:0] cmd, logic [63:0] a_raw,
                                                        logic [62:0] b_raw);
    bit [63:0] m, a, b, eb, r;
    m = {33'd0, modulus_model};
    if (m < 2) return (cmd == CMD_EQUAL) ? 31'd1 : 31'd0;
    a = signed_residue(a_raw, m);
    eb = {1'b0, b_raw};
    b = eb % m;
    r = 64'd0;
    case (cmd)
      CMD_REDUCE: r = a;
      CMD_ADD: begin
        r = a + b;
        if (r >= m) r = r - m;
      end
      CMD_SUB:    r = (a >= b) ? a - b : a + m - b;
      CMD_NEG:    r = (a != 0) ? m - a : 64'd0;
      CMD_INC: begin
        r = a + 64'd1;
        if (r == m) r = 64'd0;
      end
      CMD_DEC:    r = (a != 0) ? a - 64'd1 : m - 64'd1;
      CMD_MUL:    r = (a * b) % m;
      CMD_DIV:    r = (a * fermat_inverse(b, m)) % m;
      CMD_POW:    r = modexp(a, eb, m);
      CMD_INV:    r = fermat_inverse(a, m);
      CMD_EQUAL:  r = (a == b) ? 64'd1 : 64'd0;
      default:    r = 64'd0;
    endcase
    return r[RES_W-1:0];
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // operand mix: zero, small signed, near multiples of m and m-1, extremes, wide random
  function automatic logic [63:0] pick_operand(logic [RES_W-1:0] m_in);
    bit [63:0] m, v;
    m = {33'd0, m_in};
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: begin
        v = $urandom_range(0, 32);
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      2: v = m * $urandom_range(0, 3000) + $urandom_range(0, 2);
      3: v = (m - 64'd1) * $urandom_range(1, 3000);
      4: v = 64'd0 - m * $urandom_range(1, 3000) - $urandom_range(0, 1);
      5: begin
        case ($urandom_range(0, 2))
          0: v = A_MOST_NEG;
          1: v = A_MOST_POS;
          default: v = {64{1'b1}};
        endcase
      end
      6: v = {32'd0, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_command();
    int r;
    logic [3:0] c;
    r = $urandom_range(0, 99);
    if (r < 8) return 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
    if (r < 38) begin
      case ($urandom_range(0, 2))
        0: c = CMD_DIV;
        1: c = CMD_POW;
        default: c = CMD_INV;
      endcase
      return c;
    end
    c = 4'($urandom_range(CMD_REDUCE, CMD_MUL + 4'd1));
    return (c == CMD_MUL + 4'd1) ? CMD_EQUAL : c;
  endfunction

  // start stays high after an accept so a back-to-back beat needs no toggle of it
  task automatic send_cmd(input logic [3:0] cmd, input logic [63:0] a, input logic [62:0] b);
    int gap;
    residue_beat_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    beat.cmd   = cmd;
    beat.value = predict_residue(cmd, a, b);
    pending_residues.push_back(beat);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_residues.size() != 0);
  endtask

  task automatic set_modulus(input logic [RES_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_model = value;
  endtask

  task automatic send_random(input logic [3:0] cmd);
    logic [63:0] a, bw;
    a  = pick_operand(modulus_model);
    bw = pick_operand(modulus_model);
    // give equality a fair chance of a match
    if (cmd == CMD_EQUAL && $urandom_range(0, 1) && modulus_model >= 2)
      bw = signed_residue(a, {33'd0, modulus_model})
           + {33'd0, modulus_model} * $urandom_range(0, 5);
    send_cmd(cmd, a, bw[62:0]);
  endtask

  // ---------------- tests ----------------

  task automatic test_default_modulus();
    logic [63:0] m;
    m = {33'd0, MOD_RESET};
    steady_flow = 1'b0;
    send_cmd(CMD_REDUCE, A_MOST_NEG, 63'd0);
    send_cmd(CMD_REDUCE, A_MOST_POS, B_MAX);
    send_cmd(CMD_REDUCE, {64{1'b1}}, 63'd0);
    send_cmd(CMD_ADD,    m - 64'd1, m[62:0] - 63'd1);
    send_cmd(CMD_ADD,    {64{1'b1}}, B_MAX);
    send_cmd(CMD_SUB,    64'd0, 63'd1);
    send_cmd(CMD_SUB,    64'd5, 63'd3);
    send_cmd(CMD_NEG,    64'd0, 63'd0);
    send_cmd(CMD_NEG,    64'd1, 63'd0);
    send_cmd(CMD_INC,    m - 64'd1, 63'd0);
    send_cmd(CMD_DEC,    64'd0, 63'd0);
    send_cmd(CMD_MUL,    m - 64'd1, m[62:0] - 63'd1);
    send_cmd(CMD_MUL,    {64{1'b1}}, B_MAX);
    send_cmd(CMD_DIV,    64'd10, 63'd0);        // divide by zero
    send_cmd(CMD_DIV,    64'd10, m[62:0]);      // divisor reduces to zero
    send_cmd(CMD_DIV,    64'd10, 63'd3);
    send_cmd(CMD_POW,    64'd0, 63'd0);         // zero to the zero
    send_cmd(CMD_POW,    64'd0, m[62:0] - 63'd1);
    send_cmd(CMD_POW,    m, 63'd0);             // base reduces to zero, exponent zero
    send_cmd(CMD_POW,    64'd2, B_MAX);
    send_cmd(CMD_POW,    64'd0 - 64'd3, m[62:0] - 63'd1);
    send_cmd(CMD_INV,    64'd0, 63'd0);         // inverse of zero
    send_cmd(CMD_INV,    {64{1'b1}}, 63'd0);
    send_cmd(CMD_EQUAL,  {64{1'b1}}, m[62:0] - 63'd1);
    send_cmd(CMD_EQUAL,  64'd1, 63'd2);
    send_cmd(CMD_FIRST_UNUSED, A_MOST_POS, B_MAX);
    send_cmd(CMD_LAST_CODE,    A_MOST_NEG, B_MAX);
  endtask

  // every code under tiny, maximal, degenerate and composite moduli
  task automatic run_all_codes(input logic [RES_W-1:0] m);
    set_modulus(m);
    for (int c = 0; c <= CMD_LAST_CODE; c++) send_random(4'(c));
  endtask

  task automatic test_modulus_extremes();
    steady_flow = 1'b1;
    run_all_codes(31'd2);
    send_cmd(CMD_POW, 64'd3, 63'd0);   // nonzero base under modulus 2
    steady_flow = 1'b0;
    run_all_codes(31'd3);
    run_all_codes(MOD_MAX);
    steady_flow = 1'b1;
    run_all_codes(31'd0);
    run_all_codes(31'd1);
    steady_flow = 1'b0;
    run_all_codes(31'd1000);
  endtask

  task automatic run_random_phase(input logic [RES_W-1:0] m, input bit no_gaps);
    set_modulus(m);
    steady_flow = no_gaps;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_random(pick_command());
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  task automatic test_random_mix();
    run_random_phase(MOD_MAX, 1'b0);
    run_random_phase(31'd998244353, 1'b1);
    run_random_phase(31'd65537, 1'b0);
    run_random_phase(31'd13, 1'b0);
    run_random_phase(31'd2, 1'b1);
    run_random_phase(31'($urandom_range(2, 32'h7FFF_FFFE)), 1'b0);
    run_random_phase(31'd7, 1'b0);
    run_random_phase(MOD_RESET, 1'b1);
  endtask

  // ---------------- checking ----------------

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_residues.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat: expected none, actual %0d", $time, out_result);
      end else begin
        oldest_residue = pending_residues.pop_front();
        if (out_result !== oldest_residue.value) begin
          n_errors++;
          $display("%0t: cmd %0d result: expected %0d, actual %0d", $time,
                   oldest_residue.cmd, oldest_residue.value, out_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("prime_modular_arithmetic_unit_tb: errors");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_REDUCE;
    in_operand_a  = 64'd0;
    in_operand_b  = 63'd0;
    cfg_we        = 1'b0;
    cfg_wdata     = MOD_RESET;
    modulus_model = MOD_RESET;
    steady_flow   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_default_modulus();
    test_modulus_extremes();
    test_random_mix();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("prime_modular_arithmetic_unit_tb: clean");
    else $display("prime_modular_arithmetic_unit_tb: errors");
    $finish;
  end

endmodule
